[hdl/tgea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tgea_pkg;

	localparam int QUEUE_DEPTH  = 16;
	localparam int PTR_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_CAPACITY = 8;
	localparam int OCC_W        = $clog2(MAX_CAPACITY + 1);
	localparam int CAP_W        = 4;
	localparam int THR_W        = 16;
	localparam int TIME_W       = 32;
	localparam int ID_W         = 16;
	localparam int SERVE_W      = 16;
	localparam int APB_AW       = 3;
	localparam int APB_DW       = 32;

	localparam logic KIND_ARRIVAL   = 1'b0;
	localparam logic KIND_DEPARTURE = 1'b1;
	localparam logic STATUS_ADMIT   = 1'b0;
	localparam logic STATUS_DROP    = 1'b1;
	localparam logic REG_CAPACITY   = 1'b0;
	localparam logic REG_AGING      = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(3);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	typedef struct packed {
		logic               kind;
		logic [TIME_W-1:0]  event_time;
		logic               group;
		logic [ID_W-1:0]    person_id;
		logic [SERVE_W-1:0] hold_time;
	} req_t;

	typedef struct packed {
		logic              status;
		logic [ID_W-1:0]   granted_id;
		logic              granted_group;
		logic [TIME_W-1:0] leave_time;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [TIME_W-1:0]  arrive;
		logic [SERVE_W-1:0] serve;
	} entry_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [THR_W-1:0] age_limit;
	} cfg_t;

	typedef struct packed {
		logic             en;
		logic             grp;
		logic [PTR_W-1:0] addr;
		entry_t           data;
	} qwr_t;

	function automatic logic [PTR_W-1:0] ptr_bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/tgea_qram.sv]
`timescale 1ns / 1ps
`default_nettype none
module tgea_qram
	import tgea_pkg::*;
(
	input  wire logic             clk,
	input  wire qwr_t             wr,
	input  wire logic [PTR_W-1:0] rd_addr0,
	input  wire logic [PTR_W-1:0] rd_addr1,
	output entry_t                rd_data0,
	output entry_t                rd_data1
);

	entry_t mem0 [QUEUE_DEPTH];
	entry_t mem1 [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en && !wr.grp) begin
			mem0[wr.addr] <= wr.data;
		end
		if (wr.en && wr.grp) begin
			mem1[wr.addr] <= wr.data;
		end
		rd_data0 <= mem0[rd_addr0];
		rd_data1 <= mem1[rd_addr1];
	end

endmodule
`default_nettype wire

[hdl/tgea_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module tgea_cfg
	import tgea_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [CAP_W-1:0] cap_q;
	logic [THR_W-1:0] thr_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			thr_q <= THR_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_CAPACITY: cap_q <= pwdata[CAP_W-1:0];
				REG_AGING:    thr_q <= pwdata[THR_W-1:0];
				default:      cap_q <= cap_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CAPACITY: prdata = APB_DW'(cap_q);
			REG_AGING:    prdata = APB_DW'(thr_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.capacity  = cap_q;
	assign cfg.age_limit = thr_q;

endmodule
`default_nettype wire

[hdl/tgea_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module tgea_ctrl
	import tgea_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	output qwr_t                  qwr,
	output logic      [PTR_W-1:0] rd_addr0,
	output logic      [PTR_W-1:0] rd_addr1,
	input  wire entry_t           rd_data0,
	input  wire entry_t           rd_data1
);

	typedef enum logic [1:0] {S_IDLE, S_WAIT, S_DECIDE, S_OUT} state_t;

	state_t            state_q;
	logic [TIME_W-1:0] now_q;
	logic              grp_q;
	logic [ID_W-1:0]   id_q;
	logic              drop_q;
	logic [CNT_W-1:0]  cnt0_q, cnt1_q;
	logic [PTR_W-1:0]  head0_q, tail0_q, head1_q, tail1_q;
	logic              occ_busy_q;
	logic              occ_grp_q;
	logic [OCC_W-1:0]  occ_cnt_q;
	logic [OCC_W-1:0]  nres_q;
	rsp_t              rsp_q;

	logic              accept;
	logic [OCC_W-1:0]  cap_eff;
	logic [CNT_W-1:0]  arr_cnt;
	logic              arr_full;
	logic [TIME_W-1:0] w0, w1;
	logic [TIME_W:0]   w0_lim, w1_lim;
	logic              old0, old1;
	logic              pick;
	logic              sel_grp;
	logic [CNT_W-1:0]  sel_cnt;
	entry_t            sel_entry;
	logic              can_admit;
	logic              more;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp       = rsp_q;
	assign rd_addr0  = head0_q;
	assign rd_addr1  = head1_q;

	always_comb begin
		if (cfg.capacity == '0) begin
			cap_eff = OCC_W'(1);
		end else if (cfg.capacity > CAP_W'(MAX_CAPACITY)) begin
			cap_eff = OCC_W'(MAX_CAPACITY);
		end else begin
			cap_eff = OCC_W'(cfg.capacity);
		end
	end

	assign arr_cnt  = req.group ? cnt1_q : cnt0_q;
	assign arr_full = (arr_cnt == CNT_W'(QUEUE_DEPTH));

	assign qwr.en          = accept && (req.kind == KIND_ARRIVAL) && !arr_full;
	assign qwr.grp         = req.group;
	assign qwr.addr        = req.group ? tail1_q : tail0_q;
	assign qwr.data.id     = req.person_id;
	assign qwr.data.arrive = req.event_time;
	assign qwr.data.serve  = req.hold_time;

	assign w0     = now_q - rd_data0.arrive;
	assign w1     = now_q - rd_data1.arrive;
	assign w0_lim = {1'b0, w0} + (TIME_W + 1)'(cfg.age_limit);
	assign w1_lim = {1'b0, w1} + (TIME_W + 1)'(cfg.age_limit);
	assign old0   = {1'b0, w0} > w1_lim;
	assign old1   = {1'b0, w1} > w0_lim;

	always_comb begin
		if (cnt0_q == '0) begin
			pick = 1'b1;
		end else if (cnt1_q == '0) begin
			pick = 1'b0;
		end else if (old0) begin
			pick = 1'b0;
		end else if (old1) begin
			pick = 1'b1;
		end else begin
			pick = (cnt0_q >= cnt1_q) ? 1'b0 : 1'b1;
		end
	end

	assign sel_grp   = occ_busy_q ? occ_grp_q : pick;
	assign sel_cnt   = sel_grp ? cnt1_q : cnt0_q;
	assign sel_entry = sel_grp ? rd_data1 : rd_data0;
	assign can_admit = (occ_cnt_q < cap_eff) && (sel_cnt != '0)
		&& (nres_q < OCC_W'(MAX_CAPACITY));
	assign more      = ((occ_cnt_q + OCC_W'(1)) < cap_eff) && (sel_cnt > CNT_W'(1))
		&& ((nres_q + OCC_W'(1)) < OCC_W'(MAX_CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= '0;
			grp_q      <= 1'b0;
			id_q       <= '0;
			drop_q     <= 1'b0;
			cnt0_q     <= '0;
			cnt1_q     <= '0;
			head0_q    <= '0;
			tail0_q    <= '0;
			head1_q    <= '0;
			tail1_q    <= '0;
			occ_busy_q <= 1'b0;
			occ_grp_q  <= 1'b0;
			occ_cnt_q  <= '0;
			nres_q     <= '0;
			rsp_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						now_q  <= req.event_time;
						grp_q  <= req.group;
						id_q   <= req.person_id;
						nres_q <= '0;
						drop_q <= 1'b0;
						if (req.kind == KIND_ARRIVAL) begin
							state_q <= S_WAIT;
							if (arr_full) begin
								drop_q <= 1'b1;
							end else if (req.group) begin
								tail1_q <= ptr_bump(tail1_q);
								cnt1_q  <= cnt1_q + CNT_W'(1);
							end else begin
								tail0_q <= ptr_bump(tail0_q);
								cnt0_q  <= cnt0_q + CNT_W'(1);
							end
						end else if (occ_cnt_q != '0) begin
							state_q   <= S_WAIT;
							occ_cnt_q <= occ_cnt_q - OCC_W'(1);
							if (occ_cnt_q == OCC_W'(1)) begin
								occ_busy_q <= 1'b0;
							end
						end
					end
				end
				S_WAIT: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (drop_q) begin
						drop_q              <= 1'b0;
						nres_q              <= OCC_W'(1);
						rsp_q.status        <= STATUS_DROP;
						rsp_q.granted_id    <= id_q;
						rsp_q.granted_group <= grp_q;
						rsp_q.leave_time    <= '0;
						rsp_q.last          <= !can_admit;
						state_q             <= S_OUT;
					end else if (can_admit) begin
						nres_q              <= nres_q + OCC_W'(1);
						occ_cnt_q           <= occ_cnt_q + OCC_W'(1);
						occ_busy_q          <= 1'b1;
						occ_grp_q           <= sel_grp;
						rsp_q.status        <= STATUS_ADMIT;
						rsp_q.granted_id    <= sel_entry.id;
						rsp_q.granted_group <= sel_grp;
						rsp_q.leave_time    <= now_q + TIME_W'(sel_entry.serve);
						rsp_q.last          <= !more;
						if (sel_grp) begin
							head1_q <= ptr_bump(head1_q);
							cnt1_q  <= cnt1_q - CNT_W'(1);
						end else begin
							head0_q <= ptr_bump(head0_q);
							cnt0_q  <= cnt0_q - CNT_W'(1);
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!rsp_stall) begin
						state_q <= rsp_q.last ? S_IDLE : S_WAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/two_group_exclusive_admission_arbiter_top.sv]
// Two-group exclusive admission arbiter with aging.
// Request channel (req_valid / req_stall / req): one arrival or departure
// event per transfer, in time order. Result channel (rsp_valid / rsp_stall
// / rsp): zero to eight results per event, in order, the final one marked
// by rsp.last. A full queue gives a drop result first, then any admissions.
// Configuration: APB port, capacity at byte address 0, aging threshold at 4.
// Sequence: after the request transfer the controller passes through a wait
// state and a decide state before the first result is presented; a departure
// with nothing occupied is taken without leaving idle. Each result waits on
// the registered read of the queue head memory before it can be formed, and
// an event with no result returns to idle from the decide state.
// The request side stalls from acceptance until the last result of that
// event has been transferred. A stalled result holds its value.
// Reset clears both queues' counts and pointers, the occupancy and the
// configuration (capacity 3, aging threshold 5); no memory clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module two_group_exclusive_admission_arbiter_top
	import tgea_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output rsp_t                   rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t             cfg;
	qwr_t             qwr;
	logic [PTR_W-1:0] rd_addr0, rd_addr1;
	entry_t           rd_data0, rd_data1;

	tgea_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgea_qram u_qram (
		.clk      (clk),
		.wr       (qwr),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1),
		.rd_data0 (rd_data0),
		.rd_data1 (rd_data1)
	);

	tgea_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.qwr       (qwr),
		.rd_addr0  (rd_addr0),
		.rd_addr1  (rd_addr1),
		.rd_data0  (rd_data0),
		.rd_data1  (rd_data1)
	);

endmodule
`default_nettype wire

[sim/two_group_exclusive_admission_arbiter_top_tb.sv]
`timescale 1ns / 1ps
module two_group_exclusive_admission_arbiter_top_tb;
	import tgea_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [1:0] {OCC_G0, OCC_G1, OCC_NONE} occ_e;

	class grant_scoreboard;
		entry_t           slots[2][QUEUE_DEPTH];
		int               head[2];
		int               tail[2];
		int               waiting[2];
		occ_e             holder;
		int               occupants;
		logic [CAP_W-1:0] capacity;
		logic [THR_W-1:0] age_limit;
		rsp_t             pending_grants[$];
		int               mismatches;

		function new();
			head = '{0, 0};
			tail = '{0, 0};
			waiting = '{0, 0};
			holder = OCC_NONE;
			occupants = 0;
			capacity = CAP_RESET;
			age_limit = THR_RESET;
			mismatches = 0;
		endfunction

		function void note_event(req_t ev);
			rsp_t              batch[$];
			rsp_t              r;
			entry_t            e;
			int                g;
			int                lim;
			logic [TIME_W-1:0] d0;
			logic [TIME_W-1:0] d1;
			logic [TIME_W+1:0] w0;
			logic [TIME_W+1:0] w1;
			if (ev.kind == KIND_ARRIVAL) begin
				g = int'(ev.group);
				if (waiting[g] >= QUEUE_DEPTH) begin
					r = '0;
					r.status = STATUS_DROP;
					r.granted_id = ev.person_id;
					r.granted_group = ev.group;
					batch.push_back(r);
				end else begin
					e.id = ev.person_id;
					e.arrive = ev.event_time;
					e.serve = ev.hold_time;
					slots[g][tail[g]] = e;
					tail[g] = (tail[g] + 1) % QUEUE_DEPTH;
					waiting[g]++;
				end
			end else begin
				if (occupants == 0) return;
				occupants--;
				if (occupants == 0) holder = OCC_NONE;
			end
			lim = (capacity == 0) ? 1 :
				((capacity > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity));
			if (occupants < lim && holder == OCC_NONE) begin
				if (waiting[0] == 0 && waiting[1] != 0) begin
					holder = OCC_G1;
				end else if (waiting[1] == 0 && waiting[0] != 0) begin
					holder = OCC_G0;
				end else if (waiting[0] != 0) begin
					d0 = ev.event_time - slots[0][head[0]].arrive;
					d1 = ev.event_time - slots[1][head[1]].arrive;
					w0 = {2'b00, d0};
					w1 = {2'b00, d1};
					if (w0 > w1 + age_limit) holder = OCC_G0;
					else if (w1 > w0 + age_limit) holder = OCC_G1;
					else holder = (waiting[0] >= waiting[1]) ? OCC_G0 : OCC_G1;
				end
			end
			if (occupants < lim && holder != OCC_NONE) begin
				g = (holder == OCC_G1) ? 1 : 0;
				while (occupants < lim && waiting[g] > 0 && batch.size() < MAX_CAPACITY) begin
					e = slots[g][head[g]];
					head[g] = (head[g] + 1) % QUEUE_DEPTH;
					waiting[g]--;
					occupants++;
					r = '0;
					r.status = STATUS_ADMIT;
					r.granted_id = e.id;
					r.granted_group = g[0];
					r.leave_time = ev.event_time + TIME_W'(e.serve);
					batch.push_back(r);
				end
			end
			if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
			foreach (batch[i]) pending_grants.push_back(batch[i]);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_grants.size() == 0) begin
				$error("unexpected result: id %h group %0d", got.granted_id, got.granted_group);
				mismatches++;
				return;
			end
			want = pending_grants.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.granted_id !== want.granted_id) begin
				$error("granted_id: expected %h, got %h", want.granted_id, got.granted_id);
				mismatches++;
			end
			if (got.granted_group !== want.granted_group) begin
				$error("granted_group: expected %0d, got %0d", want.granted_group,
					got.granted_group);
				mismatches++;
			end
			if (got.leave_time !== want.leave_time) begin
				$error("leave_time: expected %h, got %h", want.leave_time, got.leave_time);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_t              rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	grant_scoreboard   grants;
	int                send_idle_pct;
	int                recv_stall_pct;
	int                cycles;
	logic [TIME_W-1:0] clock_now;
	logic              favored;
	logic              prev_kind;

	two_group_exclusive_admission_arbiter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) grants.check_result(rsp);
		rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic req_t make_event(logic kind, logic [TIME_W-1:0] t, logic grp,
		logic [ID_W-1:0] id, logic [SERVE_W-1:0] svc);
		req_t ev;
		ev.kind = kind;
		ev.event_time = t;
		ev.group = grp;
		ev.person_id = id;
		ev.hold_time = svc;
		return ev;
	endfunction

	task automatic send_event(input req_t ev);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		req_valid <= 1'b1;
		req <= ev;
		do @(posedge clk); while (req_stall);
		grants.note_event(ev);
		prev_kind = ev.kind;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (grants.pending_grants.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_CAPACITY) grants.capacity = data[CAP_W-1:0];
		else grants.age_limit = data[THR_W-1:0];
		@(posedge clk);
	endtask

	task automatic begin_phase(input int cap, input int thr, input int sidle, input int rstall,
		input logic [TIME_W-1:0] base);
		settle();
		write_reg(REG_CAPACITY, APB_DW'(cap));
		write_reg(REG_AGING, APB_DW'(thr));
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		if (clock_now < base) clock_now = base;
	endtask

	task automatic gen_events(input int count);
		req_t ev;
		int   done;
		logic kind;
		done = 0;
		while (done < count) begin
			kind = ((grants.occupants > 0 && $urandom_range(0, 99) < 45) ||
				$urandom_range(0, 99) < 4) ? KIND_DEPARTURE : KIND_ARRIVAL;
			if ($urandom_range(0, 19) == 0) favored = ~favored;
			clock_now = clock_now + TIME_W'($urandom_range(0, 3));
			if (prev_kind == KIND_DEPARTURE && kind == KIND_ARRIVAL)
				clock_now = clock_now + TIME_W'(1);
			ev = make_event(kind, clock_now,
				($urandom_range(0, 3) != 0) ? favored : ~favored,
				ID_W'($urandom), SERVE_W'($urandom));
			if (!(kind == KIND_DEPARTURE && grants.occupants == 0)) done++;
			send_event(ev);
		end
	endtask

	initial begin
		grants = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clock_now = '0;
		favored = 1'b0;
		prev_kind = KIND_ARRIVAL;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_CAPACITY, APB_DW'(1));
		send_event(make_event(KIND_DEPARTURE, '0, 1'b1, ID_W'($urandom),
			SERVE_W'($urandom)));
		send_event(make_event(KIND_ARRIVAL, '0, 1'b0, 16'h0000, 16'h0000));
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_event(make_event(KIND_ARRIVAL, TIME_W'(i + 1), 1'b0, 16'hFFFF - ID_W'(i),
				16'hFFFF));
		settle();
		write_reg(REG_CAPACITY, APB_DW'(MAX_CAPACITY));
		send_event(make_event(KIND_ARRIVAL, 32'd17, 1'b0, 16'hAAAA, 16'h1234));
		send_event(make_event(KIND_ARRIVAL, 32'd18, 1'b1, 16'h5555, 16'h0001));
		send_event(make_event(KIND_DEPARTURE, 32'd18, 1'b0, 16'h0F0F, 16'hF0F0));
		clock_now = 32'd18;

		begin_phase(3, 0, 0, 0, '0);
		gen_events(47);
		begin_phase(0, 65535, 80, 0, 32'h0001_0000);
		gen_events(47);
		begin_phase(8, 2, 0, 80, 32'h00F0_0000);
		gen_events(47);
		begin_phase(15, 5, 25, 25, 32'h5A5A_0000);
		gen_events(47);
		begin_phase(1, 1000, 0, 0, 32'hA000_0000);
		gen_events(23);
		settle();
		gen_events(24);
		begin_phase(5, 1, 25, 25, 32'hFFFF_F000);
		gen_events(47);
		settle();

		if (grants.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
